// File: hdl/wfr_pkg.sv
package wfr_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD      = 3'd0,
      KIND_EMPTY_END    = 3'd1,
      KIND_PONG_REQ     = 3'd2,
      KIND_CLOSE        = 3'd3,
      KIND_UNMASKED_ERR = 3'd4,
      KIND_OVERSIZE_ERR = 3'd5
   } kind_type;

   typedef enum logic [0:0] {
      CSR_IS_CLIENT_ROLE    = 1'd0,
      CSR_MAX_MESSAGE_BYTES = 1'd1
   } csr_index_type;

   localparam logic [3:0]  OP_CONT  = 4'd0;
   localparam logic [3:0]  OP_BINARY = 4'd2;
   localparam logic [3:0]  OP_CLOSE = 4'd8;
   localparam logic [3:0]  OP_PING  = 4'd9;
   localparam logic [6:0]  LEN_EXT16 = 7'd126;
   localparam logic [6:0]  LEN_EXT64 = 7'd127;
   localparam logic [2:0]  EXT16_LAST_COUNT = 3'd1;
   localparam logic [2:0]  EXT64_LAST_COUNT = 3'd7;
   localparam logic [2:0]  KEY_LAST_COUNT = 3'd3;
   localparam logic [31:0] MAX_MESSAGE_RESET = 32'd33554432;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] raw_byte;
      logic [7:0] mask_byte;
      logic [3:0] msg_opcode;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hdl/wfr_req_if.sv
interface wfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       new_connection;

   modport source (output valid, output in_byte, output new_connection, input ready);
   modport sink (input valid, input in_byte, input new_connection, output ready);
endinterface

// File: hdl/wfr_rsp_if.sv
interface wfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic [3:0] msg_opcode;
   logic       last;

   modport source (output valid, output kind, output data, output msg_opcode, output last,
                   input ready);
   modport sink (input valid, input kind, input data, input msg_opcode, input last,
                 output ready);
endinterface

// File: hdl/wfr_front.sv
module wfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   wfr_req_if.sink             req,
   input  wfr_pkg::qstat_type  qstat,
   output logic                push,
   output wfr_pkg::entry_type  entry
);

   logic                client_ff, client_in;
   logic [31:0]         max_ff, max_in;

   wfr_pkg::phase_type  phase_ff, phase_in;
   logic [5:0]          hb_ff, hb_in;
   logic [63:0]         fr_ff, fr_in;
   logic [2:0]          fbc_ff, fbc_in;
   logic [31:0]         key_ff, key_in;
   logic [1:0]          mpos_ff, mpos_in;
   logic [3:0]          mop_ff, mop_in;
   logic [31:0]         mlen_ff, mlen_in;
   logic                halt_ff, halt_in;

   logic                acc;
   logic                nc;
   logic [7:0]          b;
   wfr_pkg::phase_type  eff_phase;
   logic [5:0]          eff_hb;
   logic [63:0]         eff_fr;
   logic [2:0]          eff_fbc;
   logic [31:0]         eff_key;
   logic [1:0]          eff_mpos;
   logic [3:0]          eff_mop;
   logic [31:0]         eff_mlen;
   logic                eff_halt;

   logic [3:0]          op;
   logic                fin;
   logic                is_data;
   logic                masked_now;
   logic                unmasked_err;
   logic [6:0]          len7;
   logic                len7_ext;
   logic [63:0]         len_fr;
   logic                len_known;
   logic [32:0]         len_sum;
   logic                oversize;
   logic                hd_fr_zero;
   logic [3:0]          mop_hdr;
   logic                pay_end;
   logic [7:0]          mask_sel;
   wfr_pkg::phase_type  after_len_phase;

   assign req.ready = !qstat.full;
   assign acc = req.valid && req.ready;
   assign nc = req.new_connection;
   assign b = req.in_byte;

   assign eff_phase = nc ? wfr_pkg::PH_HDR0 : phase_ff;
   assign eff_hb    = nc ? 6'd0 : hb_ff;
   assign eff_fr    = nc ? 64'd0 : fr_ff;
   assign eff_fbc   = nc ? 3'd0 : fbc_ff;
   assign eff_key   = nc ? 32'd0 : key_ff;
   assign eff_mpos  = nc ? 2'd0 : mpos_ff;
   assign eff_mop   = nc ? 4'd0 : mop_ff;
   assign eff_mlen  = nc ? 32'd0 : mlen_ff;
   assign eff_halt  = nc ? 1'b0 : halt_ff;

   assign op = eff_hb[4:1];
   assign fin = eff_hb[5];
   assign is_data = (op <= wfr_pkg::OP_BINARY);
   assign masked_now = (eff_phase == wfr_pkg::PH_HDR1) ? b[7] : eff_hb[0];
   assign unmasked_err = (eff_phase == wfr_pkg::PH_HDR1) && !client_ff && !b[7];
   assign len7 = b[6:0];
   assign len7_ext = (len7 == wfr_pkg::LEN_EXT16) || (len7 == wfr_pkg::LEN_EXT64);
   assign len_fr = (eff_phase == wfr_pkg::PH_HDR1) ? {57'd0, len7} : {eff_fr[55:0], b};
   assign len_known = ((eff_phase == wfr_pkg::PH_HDR1) && !unmasked_err && !len7_ext) ||
                      ((eff_phase == wfr_pkg::PH_EXTLEN) && (eff_fbc == 3'd0));
   assign len_sum = {1'b0, eff_mlen} + {1'b0, len_fr[31:0]};
   assign oversize = len_known && is_data &&
                     ((|len_fr[63:32]) || (len_sum >= {1'b0, max_ff}));
   assign hd_fr_zero = (eff_phase == wfr_pkg::PH_KEY) ? (eff_fr == 64'd0) :
                                                        (len_fr == 64'd0);
   assign mop_hdr = (is_data && (op != wfr_pkg::OP_CONT) && (eff_mop == 4'd0)) ? op : eff_mop;
   assign pay_end = (eff_fr == 64'd1);
   assign after_len_phase = masked_now ? wfr_pkg::PH_KEY :
                            (hd_fr_zero ? wfr_pkg::PH_HDR0 : wfr_pkg::PH_PAYLOAD);

   always_comb begin
      case (eff_mpos)
         2'd0:    mask_sel = eff_key[31:24];
         2'd1:    mask_sel = eff_key[23:16];
         2'd2:    mask_sel = eff_key[15:8];
         default: mask_sel = eff_key[7:0];
      endcase
   end

   always_comb begin
      client_in = client_ff;
      max_in = max_ff;
      if (csr_we) begin
         case (csr_index)
            wfr_pkg::CSR_IS_CLIENT_ROLE:    client_in = csr_wdata[0];
            wfr_pkg::CSR_MAX_MESSAGE_BYTES: max_in = csr_wdata;
            default:                        max_in = max_ff;
         endcase
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         phase_in = eff_phase;
         if (!eff_halt) begin
            case (eff_phase)
               wfr_pkg::PH_HDR0: phase_in = wfr_pkg::PH_HDR1;
               wfr_pkg::PH_HDR1: begin
                  if (unmasked_err || oversize) begin
                     phase_in = wfr_pkg::PH_HDR1;
                  end else if (len7_ext) begin
                     phase_in = wfr_pkg::PH_EXTLEN;
                  end else begin
                     phase_in = after_len_phase;
                  end
               end
               wfr_pkg::PH_EXTLEN: begin
                  if (len_known && !oversize) begin
                     phase_in = after_len_phase;
                  end
               end
               wfr_pkg::PH_KEY: begin
                  if (eff_fbc == 3'd0) begin
                     phase_in = hd_fr_zero ? wfr_pkg::PH_HDR0 : wfr_pkg::PH_PAYLOAD;
                  end
               end
               wfr_pkg::PH_PAYLOAD: begin
                  if (pay_end) begin
                     phase_in = wfr_pkg::PH_HDR0;
                  end
               end
               default: phase_in = wfr_pkg::PH_HDR0;
            endcase
         end
      end
   end

   // Datapath and result requests.
   always_comb begin
      hb_in = hb_ff;
      fr_in = fr_ff;
      fbc_in = fbc_ff;
      key_in = key_ff;
      mpos_in = mpos_ff;
      mop_in = mop_ff;
      mlen_in = mlen_ff;
      halt_in = halt_ff;
      push = 1'b0;
      entry.kind = wfr_pkg::KIND_PAYLOAD;
      entry.raw_byte = 8'd0;
      entry.mask_byte = 8'd0;
      entry.msg_opcode = eff_mop;
      entry.last = 1'b0;
      if (acc) begin
         hb_in = eff_hb;
         fr_in = eff_fr;
         fbc_in = eff_fbc;
         key_in = eff_key;
         mpos_in = eff_mpos;
         mop_in = eff_mop;
         mlen_in = eff_mlen;
         halt_in = eff_halt;
         if (!eff_halt) begin
            case (eff_phase)
               wfr_pkg::PH_HDR0: begin
                  hb_in = {b[7], b[3:0], 1'b0};
               end
               wfr_pkg::PH_HDR1: begin
                  hb_in = {eff_hb[5:1], b[7]};
                  key_in = 32'd0;
                  if (unmasked_err) begin
                     halt_in = 1'b1;
                     push = 1'b1;
                     entry.kind = wfr_pkg::KIND_UNMASKED_ERR;
                  end else begin
                     mop_in = mop_hdr;
                     entry.msg_opcode = mop_hdr;
                     fr_in = len_fr;
                     if (len7 == wfr_pkg::LEN_EXT16) begin
                        fr_in = 64'd0;
                        fbc_in = wfr_pkg::EXT16_LAST_COUNT;
                     end else if (len7 == wfr_pkg::LEN_EXT64) begin
                        fr_in = 64'd0;
                        fbc_in = wfr_pkg::EXT64_LAST_COUNT;
                     end
                     if (oversize) begin
                        halt_in = 1'b1;
                        push = 1'b1;
                        entry.kind = wfr_pkg::KIND_OVERSIZE_ERR;
                     end else begin
                        if (len_known) begin
                           if (is_data) begin
                              mlen_in = len_sum[31:0];
                           end
                           if (masked_now) begin
                              fbc_in = wfr_pkg::KEY_LAST_COUNT;
                           end else begin
                              mpos_in = 2'd0;
                              if (hd_fr_zero && is_data && fin) begin
                                 push = 1'b1;
                                 entry.kind = wfr_pkg::KIND_EMPTY_END;
                                 entry.last = 1'b1;
                                 mop_in = 4'd0;
                                 mlen_in = 32'd0;
                              end
                           end
                        end
                        if (op == wfr_pkg::OP_PING) begin
                           push = 1'b1;
                           entry.kind = wfr_pkg::KIND_PONG_REQ;
                        end else if (op == wfr_pkg::OP_CLOSE) begin
                           push = 1'b1;
                           entry.kind = wfr_pkg::KIND_CLOSE;
                           entry.last = 1'b1;
                           entry.msg_opcode = 4'd0;
                           mop_in = 4'd0;
                           mlen_in = 32'd0;
                        end
                     end
                  end
               end
               wfr_pkg::PH_EXTLEN: begin
                  fr_in = len_fr;
                  if (!len_known) begin
                     fbc_in = eff_fbc - 3'd1;
                  end else if (oversize) begin
                     halt_in = 1'b1;
                     push = 1'b1;
                     entry.kind = wfr_pkg::KIND_OVERSIZE_ERR;
                  end else begin
                     if (is_data) begin
                        mlen_in = len_sum[31:0];
                     end
                     if (masked_now) begin
                        fbc_in = wfr_pkg::KEY_LAST_COUNT;
                     end else begin
                        mpos_in = 2'd0;
                        if (hd_fr_zero && is_data && fin) begin
                           push = 1'b1;
                           entry.kind = wfr_pkg::KIND_EMPTY_END;
                           entry.last = 1'b1;
                           mop_in = 4'd0;
                           mlen_in = 32'd0;
                        end
                     end
                  end
               end
               wfr_pkg::PH_KEY: begin
                  key_in = {eff_key[23:0], b};
                  if (eff_fbc != 3'd0) begin
                     fbc_in = eff_fbc - 3'd1;
                  end else begin
                     mpos_in = 2'd0;
                     if (hd_fr_zero && is_data && fin) begin
                        push = 1'b1;
                        entry.kind = wfr_pkg::KIND_EMPTY_END;
                        entry.last = 1'b1;
                        mop_in = 4'd0;
                        mlen_in = 32'd0;
                     end
                  end
               end
               wfr_pkg::PH_PAYLOAD: begin
                  fr_in = eff_fr - 64'd1;
                  if (is_data) begin
                     push = 1'b1;
                     entry.kind = wfr_pkg::KIND_PAYLOAD;
                     entry.raw_byte = b;
                     entry.mask_byte = mask_sel;
                     entry.last = pay_end && fin;
                     mpos_in = eff_mpos + 2'd1;
                     if (pay_end && fin) begin
                        mop_in = 4'd0;
                        mlen_in = 32'd0;
                     end
                  end
               end
               default: begin
                  hb_in = eff_hb;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         client_ff <= 1'b0;
         max_ff <= wfr_pkg::MAX_MESSAGE_RESET;
         phase_ff <= wfr_pkg::PH_HDR0;
         hb_ff <= 6'd0;
         fr_ff <= 64'd0;
         fbc_ff <= 3'd0;
         key_ff <= 32'd0;
         mpos_ff <= 2'd0;
         mop_ff <= 4'd0;
         mlen_ff <= 32'd0;
         halt_ff <= 1'b0;
      end else begin
         client_ff <= client_in;
         max_ff <= max_in;
         phase_ff <= phase_in;
         hb_ff <= hb_in;
         fr_ff <= fr_in;
         fbc_ff <= fbc_in;
         key_ff <= key_in;
         mpos_ff <= mpos_in;
         mop_ff <= mop_in;
         mlen_ff <= mlen_in;
         halt_ff <= halt_in;
      end
   end

endmodule

// File: hdl/wfr_queue.sv
module wfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wfr_pkg::entry_type  push_entry,
   input  logic                pop,
   output wfr_pkg::entry_type  head,
   output wfr_pkg::qstat_type  qstat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   wfr_pkg::entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign qstat.full = (count_ff == CNT_FULL);
   assign qstat.empty = (count_ff == '0);
   assign head = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && qstat.full))
      else $error("Request pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) !(pop && qstat.empty))
      else $error("Request popped from an empty queue.");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Queue count did not rise on a push.");
   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("Queue count did not fall on a pop.");

endmodule

// File: hdl/wfr_back.sv
module wfr_back (
   input  logic                clock,
   input  logic                reset,
   input  wfr_pkg::entry_type  head,
   input  wfr_pkg::qstat_type  qstat,
   output logic                pop,
   wfr_rsp_if.source           rsp
);

   logic                valid_ff, valid_in;
   wfr_pkg::kind_type   kind_ff;
   logic [7:0]          data_ff;
   logic [3:0]          opcode_ff;
   logic                last_ff;

   assign pop = !qstat.empty && (!valid_ff || rsp.ready);
   assign valid_in = pop || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= head.kind;
         data_ff <= head.raw_byte ^ head.mask_byte;
         opcode_ff <= head.msg_opcode;
         last_ff <= head.last;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.kind = kind_ff;
   assign rsp.data = data_ff;
   assign rsp.msg_opcode = opcode_ff;
   assign rsp.last = last_ff;

endmodule

// File: hdl/websocket_frame_receiver_top.sv
// Channel   Direction  Payload                                Handshake
// req_ch    in         in_byte[7:0], new_connection           valid / ready
// rsp_ch    out        kind[2:0], data[7:0], msg_opcode[3:0], last  valid / ready
// csr_*     in         csr_index selects register, csr_wdata[31:0]  csr_we, no wait
//
// One byte is accepted every cycle while the result queue is not full. The front
// part handles each byte as it is accepted, so input stalls come only from the
// result queue of QUEUE_DEPTH entries and the output register behind it.
// Reset is synchronous and takes effect at once, with no clearing pass.
// When the result side stalls, req_ch.ready falls only once the queue is full.
module websocket_frame_receiver_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   wfr_req_if.sink     req_ch,
   wfr_rsp_if.source   rsp_ch
);

   logic                push;
   logic                pop;
   wfr_pkg::entry_type  push_entry;
   wfr_pkg::entry_type  head;
   wfr_pkg::qstat_type  qstat;

   wfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .qstat     (qstat),
      .push      (push),
      .entry     (push_entry)
   );

   wfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   wfr_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam logic [3:0] OP_TEXT     = 4'd1;
   localparam logic [3:0] OP_RESERVED = 4'd3;
   localparam logic [3:0] OP_PONG     = 4'd10;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PRESSURE_CYCLES = 300;

   typedef struct {
      logic [7:0] value;
      logic       restart;
   } stream_item_type;

   typedef struct {
      wfr_pkg::kind_type kind;
      logic [7:0]        data;
      logic [3:0]        msg_opcode;
      logic              last;
   } ws_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   wfr_req_if req_ch ();
   wfr_rsp_if rsp_ch ();

   websocket_frame_receiver_top uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   stream_item_type tx_bytes[$];
   ws_result_type   expected_results[$];
   stream_item_type drv_item;
   int           mismatch_count = 0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           hold_left = 0;
   int           idle_cycles = 0;
   bit           drv_calm = 1'b0;
   bit           rcv_calm = 1'b0;

   // Register copies and parser state of the predictor.
   logic        client_role = 1'b0;
   logic [31:0] max_bytes = wfr_pkg::MAX_MESSAGE_RESET;
   wfr_pkg::phase_type fr_phase;
   logic [5:0]  hdr;
   logic [63:0] remaining;
   logic [2:0]  field_cnt;
   logic [31:0] key;
   logic [1:0]  key_pos;
   logic [3:0]  msg_op;
   logic [31:0] msg_len;
   logic        parse_halted;

   // Generator bookkeeping, used to decide where a fresh connection is needed and which opcode a data frame gets.
   logic [63:0] gen_acc = '0;
   logic        gen_in_msg = 1'b0;
   logic        gen_restart = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic clear_parser();
      fr_phase = wfr_pkg::PH_HDR0;
      hdr = '0;
      remaining = '0;
      field_cnt = '0;
      key = '0;
      key_pos = '0;
      msg_op = wfr_pkg::OP_CONT;
      msg_len = '0;
      parse_halted = 1'b0;
   endtask

   task automatic emit(wfr_pkg::kind_type kind, logic [7:0] data, logic last);
      ws_result_type r;
      r.kind = kind;
      r.data = data;
      r.msg_opcode = msg_op;
      r.last = last;
      expected_results.push_back(r);
   endtask

   task automatic header_done();
      key_pos = '0;
      if (remaining == 0) begin
         fr_phase = wfr_pkg::PH_HDR0;
         if (hdr[4:1] <= wfr_pkg::OP_BINARY && hdr[5]) begin
            emit(wfr_pkg::KIND_EMPTY_END, 8'h00, 1'b1);
            msg_op = wfr_pkg::OP_CONT;
            msg_len = '0;
         end
      end else begin
         fr_phase = wfr_pkg::PH_PAYLOAD;
      end
   endtask

   task automatic length_known();
      logic [63:0] lim;
      logic        is_data;
      lim = {32'd0, max_bytes};
      is_data = hdr[4:1] <= wfr_pkg::OP_BINARY;
      if (is_data && (remaining >= lim || {32'd0, msg_len} + remaining >= lim)) begin
         parse_halted = 1'b1;
         emit(wfr_pkg::KIND_OVERSIZE_ERR, 8'h00, 1'b0);
      end else begin
         if (is_data)
            msg_len = msg_len + remaining[31:0];
         if (hdr[0]) begin
            fr_phase = wfr_pkg::PH_KEY;
            field_cnt = wfr_pkg::KEY_LAST_COUNT;
         end else begin
            header_done();
         end
      end
   endtask

   task automatic parse_byte(logic [7:0] b, logic restart);
      logic [3:0] op;
      logic [7:0] plain;
      logic       at_end;
      if (restart)
         clear_parser();
      if (!parse_halted) begin
         case (fr_phase)
            wfr_pkg::PH_HDR0: begin
               hdr = {b[7], b[3:0], 1'b0};
               fr_phase = wfr_pkg::PH_HDR1;
            end
            wfr_pkg::PH_HDR1: begin
               hdr[0] = b[7];
               key = '0;
               op = hdr[4:1];
               if (!client_role && !hdr[0]) begin
                  parse_halted = 1'b1;
                  emit(wfr_pkg::KIND_UNMASKED_ERR, 8'h00, 1'b0);
               end else begin
                  if (op <= wfr_pkg::OP_BINARY && op != wfr_pkg::OP_CONT &&
                      msg_op == wfr_pkg::OP_CONT)
                     msg_op = op;
                  remaining = '0;
                  if (b[6:0] == wfr_pkg::LEN_EXT16) begin
                     fr_phase = wfr_pkg::PH_EXTLEN;
                     field_cnt = wfr_pkg::EXT16_LAST_COUNT;
                  end else if (b[6:0] == wfr_pkg::LEN_EXT64) begin
                     fr_phase = wfr_pkg::PH_EXTLEN;
                     field_cnt = wfr_pkg::EXT64_LAST_COUNT;
                  end else begin
                     remaining = {57'd0, b[6:0]};
                     length_known();
                  end
                  if (op == wfr_pkg::OP_PING) begin
                     emit(wfr_pkg::KIND_PONG_REQ, 8'h00, 1'b0);
                  end else if (op == wfr_pkg::OP_CLOSE) begin
                     msg_op = wfr_pkg::OP_CONT;
                     msg_len = '0;
                     emit(wfr_pkg::KIND_CLOSE, 8'h00, 1'b1);
                  end
               end
            end
            wfr_pkg::PH_EXTLEN: begin
               remaining = {remaining[55:0], b};
               if (field_cnt == 0)
                  length_known();
               else
                  field_cnt = field_cnt - 3'd1;
            end
            wfr_pkg::PH_KEY: begin
               key = {key[23:0], b};
               if (field_cnt == 0)
                  header_done();
               else
                  field_cnt = field_cnt - 3'd1;
            end
            wfr_pkg::PH_PAYLOAD: begin
               remaining = remaining - 64'd1;
               at_end = (remaining == 0);
               if (hdr[4:1] <= wfr_pkg::OP_BINARY) begin
                  plain = b ^ key[31 - 8 * key_pos -: 8];
                  key_pos = key_pos + 2'd1;
                  emit(wfr_pkg::KIND_PAYLOAD, plain, at_end && hdr[5]);
                  if (at_end) begin
                     fr_phase = wfr_pkg::PH_HDR0;
                     if (hdr[5]) begin
                        msg_op = wfr_pkg::OP_CONT;
                        msg_len = '0;
                     end
                  end
               end else if (at_end) begin
                  fr_phase = wfr_pkg::PH_HDR0;
               end
            end
            default: fr_phase = wfr_pkg::PH_HDR0;
         endcase
      end
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_result();
      ws_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing expected, kind", {5'd0, rsp_ch.kind}, 8'h00);
      end else begin
         want = expected_results.pop_front();
         if (rsp_ch.kind !== want.kind)
            report_mismatch("kind", {5'd0, rsp_ch.kind}, {5'd0, want.kind});
         if (rsp_ch.data !== want.data)
            report_mismatch("data", rsp_ch.data, want.data);
         if (rsp_ch.msg_opcode !== want.msg_opcode)
            report_mismatch("msg_opcode", {4'd0, rsp_ch.msg_opcode}, {4'd0, want.msg_opcode});
         if (rsp_ch.last !== want.last)
            report_mismatch("last", {7'd0, rsp_ch.last}, {7'd0, want.last});
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            parse_byte(req_ch.in_byte, req_ch.new_connection);
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
               drv_item = tx_bytes.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.in_byte <= drv_item.value;
               req_ch.new_connection <= drv_item.restart;
               if (!drv_calm)
                  send_gap = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rcv_calm)
               recv_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic push_byte(logic [7:0] value, logic restart);
      stream_item_type it;
      it.value = value;
      it.restart = restart;
      tx_bytes.push_back(it);
      if (restart) begin
         gen_acc = '0;
         gen_in_msg = 1'b0;
      end
   endtask

   // Length form: 0 seven-bit field, 1 sixteen-bit field, 2 sixty-four-bit field.
   task automatic add_frame(logic fin, logic [3:0] op, logic masked, logic [63:0] len,
                            int form);
      logic [31:0] mkey;
      logic [2:0]  rsv;
      logic [6:0]  len7;
      int          i;
      mkey = $urandom;
      rsv = 3'($urandom_range(0, 7));
      len7 = (form == 0) ? len[6:0] :
             (form == 1) ? wfr_pkg::LEN_EXT16 : wfr_pkg::LEN_EXT64;
      push_byte({fin, rsv, op}, gen_restart);
      gen_restart = 1'b0;
      push_byte({masked, len7}, 1'b0);
      if (!client_role && !masked) begin
         gen_restart = 1'b1;
         return;
      end
      if (form == 1) begin
         push_byte(len[15:8], 1'b0);
         push_byte(len[7:0], 1'b0);
      end else if (form == 2) begin
         for (i = 7; i >= 0; i--)
            push_byte(len[8 * i +: 8], 1'b0);
      end
      if (op <= wfr_pkg::OP_BINARY) begin
         if (len >= {32'd0, max_bytes} || gen_acc + len >= {32'd0, max_bytes}) begin
            gen_restart = 1'b1;
            return;
         end
         gen_acc = fin ? 64'd0 : gen_acc + len;
         gen_in_msg = !fin;
      end else if (op == wfr_pkg::OP_CLOSE) begin
         gen_acc = '0;
         gen_in_msg = 1'b0;
      end
      if (masked) begin
         push_byte(mkey[31:24], 1'b0);
         push_byte(mkey[23:16], 1'b0);
         push_byte(mkey[15:8], 1'b0);
         push_byte(mkey[7:0], 1'b0);
      end
      for (i = 0; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic add_random_frames(int n);
      int          pick;
      int          form;
      logic [3:0]  op;
      logic        fin;
      logic        masked;
      logic [63:0] len;
      while (tx_bytes.size() < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            gen_restart = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               if (gen_in_msg)
                  op = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 2))
                                                   : wfr_pkg::OP_CONT;
               else
                  op = ($urandom_range(0, 7) == 0) ? wfr_pkg::OP_CONT
                                                   : 4'($urandom_range(1, 2));
            end else if (pick < 78) begin
               op = wfr_pkg::OP_PING;
            end else if (pick < 84) begin
               op = wfr_pkg::OP_CLOSE;
            end else if (pick < 90) begin
               op = OP_PONG;
            end else begin
               op = 4'($urandom_range(OP_RESERVED, 15));
            end
            fin = (op <= wfr_pkg::OP_BINARY) ? ($urandom_range(0, 99) < 65)
                                             : ($urandom_range(0, 9) != 0);
            masked = client_role ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               form = 0;
               len = 64'd125;
            end else if (pick < 75) begin
               form = 0;
               len = 64'($urandom_range(0, 10));
            end else if (pick < 88) begin
               form = 1;
               len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                                 : 64'($urandom_range(0, 24));
            end else begin
               form = 2;
               len = 64'($urandom_range(0, 16));
               if (op <= wfr_pkg::OP_BINARY && $urandom_range(0, 3) == 0) begin
                  len = {$urandom, $urandom};
                  len[32 + $urandom_range(0, 31)] = 1'b1;
               end
            end
            if ($urandom_range(0, 32) == 0)
               gen_restart = 1'b1;
            add_frame(fin, op, masked, len, form);
            if ($urandom_range(0, 24) == 0) begin
               repeat ($urandom_range(1, 3))
                  if (tx_bytes.size() != 0)
                     tx_bytes.pop_back();
               gen_restart = 1'b1;
            end
         end
      end
   endtask

   task automatic write_csr(wfr_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == wfr_pkg::CSR_IS_CLIENT_ROLE)
         client_role = value[0];
      else
         max_bytes = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (tx_bytes.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          ph;
      logic        role_sel;
      logic [31:0] max_sel;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      req_ch.new_connection = 1'b0;
      rsp_ch.ready = 1'b0;
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset settings, which act as server.
      add_frame(1'b1, OP_TEXT, 1'b1, 64'd2, 0);
      add_frame(1'b0, wfr_pkg::OP_BINARY, 1'b1, 64'd1, 1);
      add_frame(1'b0, wfr_pkg::OP_CONT, 1'b1, 64'd0, 0);
      add_frame(1'b1, wfr_pkg::OP_CONT, 1'b1, 64'd1, 2);
      add_frame(1'b1, OP_TEXT, 1'b1, 64'd0, 0);
      add_frame(1'b1, wfr_pkg::OP_PING, 1'b1, 64'd0, 0);
      add_frame(1'b0, OP_TEXT, 1'b1, 64'd1, 0);
      add_frame(1'b1, wfr_pkg::OP_CLOSE, 1'b1, 64'd2, 0);
      add_frame(1'b1, OP_PONG, 1'b1, 64'd1, 0);
      add_frame(1'b1, OP_RESERVED, 1'b1, 64'd0, 0);
      add_frame(1'b1, OP_TEXT, 1'b0, 64'd0, 0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      gen_restart = 1'b1;
      add_frame(1'b1, wfr_pkg::OP_BINARY, 1'b1, 64'h8000_0000_0000_0000, 2);
      gen_restart = 1'b1;
      add_frame(1'b1, wfr_pkg::OP_BINARY, 1'b1, 64'd3, 0);
      settle();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin role_sel = 1'b1; max_sel = wfr_pkg::MAX_MESSAGE_RESET; end
            1: begin role_sel = 1'b0; max_sel = 32'd1; end
            2: begin role_sel = 1'b1; max_sel = 32'hFFFF_FFFF; end
            3: begin role_sel = 1'b0; max_sel = 32'd40; end
            4: begin role_sel = 1'($urandom_range(0, 1)); max_sel = $urandom_range(16, 400); end
            default: begin role_sel = 1'b0; max_sel = wfr_pkg::MAX_MESSAGE_RESET; end
         endcase
         write_csr(wfr_pkg::CSR_IS_CLIENT_ROLE, {31'd0, role_sel});
         write_csr(wfr_pkg::CSR_MAX_MESSAGE_BYTES, max_sel);
         drv_calm = (ph == 2 || ph == 4);
         rcv_calm = (ph == 1 || ph == 4);
         gen_restart = 1'b1;
         if (ph == 2) begin
            @(negedge clock);
            hold_left = PRESSURE_CYCLES;
         end
         add_random_frames(150);
         settle();
      end

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
hdl/wfr_pkg.sv
hdl/wfr_req_if.sv
hdl/wfr_rsp_if.sv
hdl/wfr_front.sv
hdl/wfr_queue.sv
hdl/wfr_back.sv
hdl/websocket_frame_receiver_top.sv
test/tb.sv
